/* rtl/fnv_oh_pkg.sv */
// Package for the FNV-1a ordered/unordered hash block.
// Constants, operation codes and controller/datapath link types. No dependencies.
package fnv_oh_pkg;

    localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;

    localparam logic [2:0] KIND_ADD_ORD   = 3'd0;
    localparam logic [2:0] KIND_ADD_UNORD = 3'd1;
    localparam logic [2:0] KIND_INCORP    = 3'd2;
    localparam logic [2:0] KIND_RST_ORD   = 3'd3;
    localparam logic [2:0] KIND_RST_UNORD = 3'd4;
    localparam logic [2:0] KIND_QUERY     = 3'd5;

    localparam logic [1:0] WIDTH_BYTE  = 2'd0;
    localparam logic [1:0] WIDTH_WORD  = 2'd1;

    typedef struct packed {
        logic       start;
        logic       step;
        logic       reload;
        logic       commit;
        logic [2:0] kind;
    } t_cmd;

    typedef struct packed {
        logic out_full;
    } t_stat;

    // One FNV-1a byte step; prime is 2^40 + 2^8 + 0xb3.
    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

/* rtl/fnv_oh_if.sv */
// Handshake interfaces for the input and result words.
// Depends on nothing.
interface fnv_oh_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] data_value;
    logic [1:0]  value_width;
    modport source (output valid, kind, data_value, value_width, input ready);
    modport sink   (input valid, kind, data_value, value_width, output ready);
endinterface

interface fnv_oh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;
    logic [63:0] unordered_digest;
    modport source (output valid, hash_value, unordered_digest, input ready);
    modport sink   (input valid, hash_value, unordered_digest, output ready);
endinterface

/* rtl/fnv_oh_ctrl.sv */
// Controller: sequences byte steps for one word at a time.
// Depends on fnv_oh_pkg.
module fnv_oh_ctrl
    import fnv_oh_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_kind,
    input  logic [1:0] i_width,
    output logic       o_in_ready,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} t_state;

    t_state      r_state;
    logic [2:0]  r_kind;
    logic [3:0]  r_cnt;
    logic        r_two;
    logic        accept;
    logic [4:0]  nbytes;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        unique case (i_kind)
            KIND_ADD_ORD, KIND_ADD_UNORD: begin
                unique case (i_width)
                    WIDTH_BYTE: nbytes = 5'd1;
                    WIDTH_WORD: nbytes = 5'd4;
                    default:    nbytes = 5'd8;
                endcase
            end
            KIND_INCORP, KIND_QUERY: nbytes = 5'd16;
            default:                 nbytes = 5'd0;
        endcase
    end

    always_comb begin
        o_cmd.start  = accept;
        o_cmd.step   = (r_state == S_RUN);
        o_cmd.reload = (r_state == S_RUN) && r_two && (r_cnt == 4'd8);
        o_cmd.commit = (r_state == S_FIN) && !i_stat.out_full;
        o_cmd.kind   = accept ? i_kind : r_kind;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= KIND_ADD_ORD;
            r_cnt   <= 4'd0;
            r_two   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_kind <= i_kind;
                        r_two  <= (nbytes == 5'd16);
                        r_cnt  <= 4'(nbytes - 5'd1);
                        r_state <= (nbytes == 5'd0) ? S_FIN : S_RUN;
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt - 4'd1;
                    if (r_cnt == 4'd0) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!i_stat.out_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/fnv_oh_dp.sv */
// Datapath: hash state, byte step unit and result register.
// Depends on fnv_oh_pkg.
module fnv_oh_dp
    import fnv_oh_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [63:0] i_data,
    output t_stat       o_stat,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_hash,
    output logic [63:0] o_digest
);

    logic [63:0] r_hash, r_xor, r_sum, r_acc, r_data;
    logic [63:0] r_o_hash, r_o_digest;
    logic        r_o_valid;
    logic [63:0] n_hash, n_xor, n_sum, n_digest;

    assign o_stat.out_full = r_o_valid && !i_ready;
    assign o_valid  = r_o_valid;
    assign o_hash   = r_o_hash;
    assign o_digest = r_o_digest;

    always_comb begin
        n_hash   = r_hash;
        n_xor    = r_xor;
        n_sum    = r_sum;
        n_digest = 64'd0;
        unique case (i_cmd.kind)
            KIND_ADD_ORD: n_hash = r_acc;
            KIND_ADD_UNORD: begin
                n_xor = r_xor ^ r_acc;
                n_sum = r_sum + r_acc;
            end
            KIND_INCORP: begin
                n_hash = r_acc;
                n_xor  = FNV_BASIS;
                n_sum  = 64'd0;
            end
            KIND_RST_ORD: n_hash = FNV_BASIS;
            KIND_RST_UNORD: begin
                n_xor = FNV_BASIS;
                n_sum = 64'd0;
            end
            KIND_QUERY: n_digest = r_acc;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash    <= FNV_BASIS;
            r_xor     <= FNV_BASIS;
            r_sum     <= 64'd0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_hash    <= n_hash;
                r_xor     <= n_xor;
                r_sum     <= n_sum;
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_acc  <= (i_cmd.kind == KIND_ADD_ORD || i_cmd.kind == KIND_INCORP)
                      ? r_hash : FNV_BASIS;
            r_data <= (i_cmd.kind == KIND_INCORP || i_cmd.kind == KIND_QUERY)
                      ? r_xor : i_data;
        end else if (i_cmd.step) begin
            r_acc  <= fnv_step(r_acc, r_data[7:0]);
            r_data <= i_cmd.reload ? r_sum : (r_data >> 8);
        end
        if (i_cmd.commit) begin
            r_o_hash   <= n_hash;
            r_o_digest <= n_digest;
        end
    end

endmodule

/* rtl/fnv1a_ordered_unordered_hash.sv */
// FNV-1a 64-bit hash with ordered and order-independent accumulators.
// Each word takes n byte steps after accept, n = 1, 4 or 8 data bytes,
// 16 for incorporate and query, 0 for resets and unused kinds.
// One byte step per cycle through the single byte step unit; the next word is
// accepted only once the result is in the output register. Synchronous
// active-low reset loads both hashes with the offset basis and clears the sum.
module fnv1a_ordered_unordered_hash
    import fnv_oh_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    fnv_oh_in_if.sink    i_in,
    fnv_oh_out_if.source o_out
);

    t_cmd  cmd;
    t_stat stat;

    fnv_oh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_kind     (i_in.kind),
        .i_width    (i_in.value_width),
        .o_in_ready (i_in.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fnv_oh_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_data   (i_in.data_value),
        .o_stat   (stat),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_hash   (o_out.hash_value),
        .o_digest (o_out.unordered_digest)
    );

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for fnv1a_ordered_unordered_hash: directed, sequence and random words.
// Predicts ordered hash and unordered digest for every accepted word.
// Depends on fnv_oh_pkg and the fnv_oh_in_if / fnv_oh_out_if interfaces.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fnv_oh_pkg::*;

    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;
    localparam logic [1:0] WIDTH_DWORD  = 2'd2;
    localparam logic [1:0] WIDTH_SPARE  = 2'd3;
    localparam int         DRAIN_CYCLES = 24;

    typedef struct packed {
        logic [63:0] hash_value;
        logic [63:0] digest;
    } t_hash_pair;

    logic i_clk = 1'b0;
    logic i_rst_n;

    fnv_oh_in_if  in_if();
    fnv_oh_out_if out_if();

    fnv1a_ordered_unordered_hash u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_hash_pair  exp_hashes[$];
    logic [63:0] acc_ordered;
    logic [63:0] acc_xor;
    logic [63:0] acc_sum;
    int          mismatches = 0;
    int          gap_max    = 12;
    int          stall_max  = 12;

    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [63:0] v,
                                             input int nbytes);
        for (int i = 0; i < nbytes; i++) begin
            h = (h ^ {56'd0, v[8*i +: 8]}) * FNV_PRIME;
        end
        return h;
    endfunction

    task automatic predict_hash(input logic [2:0] kind, input logic [63:0] data,
                                input logic [1:0] width);
        int          nbytes;
        logic [63:0] h;
        t_hash_pair  res;
        nbytes = (width == WIDTH_BYTE) ? 1 : (width == WIDTH_WORD) ? 4 : 8;
        res.digest = '0;
        case (kind)
            KIND_ADD_ORD: begin
                acc_ordered = fnv_fold(acc_ordered, data, nbytes);
            end
            KIND_ADD_UNORD: begin
                h = fnv_fold(FNV_BASIS, data, nbytes);
                acc_xor = acc_xor ^ h;
                acc_sum = acc_sum + h;
            end
            KIND_INCORP: begin
                acc_ordered = fnv_fold(fnv_fold(acc_ordered, acc_xor, 8), acc_sum, 8);
                acc_xor = FNV_BASIS;
                acc_sum = '0;
            end
            KIND_RST_ORD: begin
                acc_ordered = FNV_BASIS;
            end
            KIND_RST_UNORD: begin
                acc_xor = FNV_BASIS;
                acc_sum = '0;
            end
            KIND_QUERY: begin
                res.digest = fnv_fold(fnv_fold(FNV_BASIS, acc_xor, 8), acc_sum, 8);
            end
            default: ;
        endcase
        res.hash_value = acc_ordered;
        exp_hashes.push_back(res);
    endtask

    // valid is left high on return; the next word or the end of the main sequence decides its level
    task automatic send_word(input logic [2:0] kind, input logic [63:0] data,
                             input logic [1:0] width);
        int gap;
        gap = $urandom_range(gap_max, 0);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.kind        <= kind;
        in_if.data_value  <= data;
        in_if.value_width <= width;
        do @(posedge i_clk); while (!in_if.ready);
        predict_hash(kind, data, width);
    endtask

    function automatic logic [63:0] rand_data();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return '1;
            2:       return 64'(1) << $urandom_range(63, 0);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [2:0] rand_kind();
        int r;
        r = $urandom_range(99, 0);
        if (r < 30)      return KIND_ADD_ORD;
        else if (r < 60) return KIND_ADD_UNORD;
        else if (r < 70) return KIND_INCORP;
        else if (r < 80) return KIND_QUERY;
        else if (r < 86) return KIND_RST_ORD;
        else if (r < 92) return KIND_RST_UNORD;
        else if (r < 96) return KIND_SPARE_6;
        else             return KIND_SPARE_7;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] exp_v,
                                   input logic [63:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch %s: expected %h got %h", $realtime, what, exp_v, act_v);
    endtask

    initial begin
        t_hash_pair exp_r;
        int         stall;
        out_if.ready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = $urandom_range(stall_max, 0);
            if (stall > 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            if (exp_hashes.size() == 0) begin
                report_mismatch("unexpected word hash", '0, out_if.hash_value);
            end else begin
                exp_r = exp_hashes.pop_front();
                if (out_if.hash_value !== exp_r.hash_value)
                    report_mismatch("hash_value", exp_r.hash_value, out_if.hash_value);
                if (out_if.unordered_digest !== exp_r.digest)
                    report_mismatch("unordered_digest", exp_r.digest,
                                    out_if.unordered_digest);
            end
        end
    end

    task automatic test_directed();
        send_word(KIND_QUERY, '0, WIDTH_BYTE);
        send_word(KIND_ADD_ORD, '0, WIDTH_BYTE);
        send_word(KIND_ADD_ORD, '1, WIDTH_BYTE);
        send_word(KIND_ADD_ORD, '1, WIDTH_WORD);
        send_word(KIND_ADD_ORD, '1, WIDTH_DWORD);
        send_word(KIND_ADD_ORD, 64'h0123_4567_89ab_cdef, WIDTH_SPARE);
        send_word(KIND_ADD_ORD, '0, WIDTH_DWORD);
        send_word(KIND_ADD_UNORD, '1, WIDTH_BYTE);
        send_word(KIND_ADD_UNORD, 64'h8000_0000_0000_0000, WIDTH_DWORD);
        send_word(KIND_ADD_UNORD, 64'hdead_beef_1234_5678, WIDTH_WORD);
        send_word(KIND_ADD_UNORD, '0, WIDTH_SPARE);
        send_word(KIND_QUERY, '1, WIDTH_SPARE);
        send_word(KIND_INCORP, '1, WIDTH_SPARE);
        send_word(KIND_QUERY, '0, WIDTH_BYTE);
        send_word(KIND_INCORP, '0, WIDTH_BYTE);
        send_word(KIND_ADD_UNORD, 64'h5555_5555_5555_5555, WIDTH_DWORD);
        send_word(KIND_RST_UNORD, '1, WIDTH_SPARE);
        send_word(KIND_QUERY, 64'haaaa_aaaa_aaaa_aaaa, WIDTH_WORD);
        send_word(KIND_RST_ORD, '1, WIDTH_SPARE);
        send_word(KIND_SPARE_6, '1, WIDTH_SPARE);
        send_word(KIND_SPARE_7, '0, WIDTH_BYTE);
        send_word(KIND_ADD_ORD, 64'haaaa_aaaa_aaaa_aaaa, WIDTH_DWORD);
        send_word(KIND_ADD_ORD, 64'h5555_5555_5555_5555, WIDTH_DWORD);
    endtask

    // well-formed unordered sets: optional clear, one to five values, query, optional fold in
    task automatic test_unordered_sets();
        int n;
        repeat (30) begin
            if ($urandom_range(1, 0))
                send_word(KIND_RST_UNORD, rand_data(), 2'($urandom_range(3, 0)));
            n = $urandom_range(5, 1);
            repeat (n) begin
                send_word(KIND_ADD_UNORD, rand_data(), 2'($urandom_range(3, 0)));
                if ($urandom_range(3, 0) == 0)
                    send_word(KIND_ADD_ORD, rand_data(), 2'($urandom_range(3, 0)));
            end
            send_word(KIND_QUERY, rand_data(), 2'($urandom_range(3, 0)));
            if ($urandom_range(3, 0) != 0)
                send_word(KIND_INCORP, rand_data(), 2'($urandom_range(3, 0)));
        end
    endtask

    task automatic test_random_mix();
        repeat (400)
            send_word(rand_kind(), rand_data(), 2'($urandom_range(3, 0)));
    endtask

    task automatic test_back_to_back();
        gap_max   = 0;
        stall_max = 0;
        repeat (40)
            send_word(rand_kind(), rand_data(), 2'($urandom_range(3, 0)));
        stall_max = 12;
        repeat (20)
            send_word(rand_kind(), rand_data(), 2'($urandom_range(3, 0)));
        gap_max = 12;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.kind        = KIND_ADD_ORD;
        in_if.data_value  = '0;
        in_if.value_width = WIDTH_BYTE;
        acc_ordered       = FNV_BASIS;
        acc_xor           = FNV_BASIS;
        acc_sum           = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_unordered_sets();
        test_random_mix();
        test_back_to_back();

        in_if.valid <= 1'b0;
        while (exp_hashes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("[fnv1a_ordered_unordered_hash] OK");
        else
            $display("[fnv1a_ordered_unordered_hash] ERROR");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("[fnv1a_ordered_unordered_hash] ERROR");
        $finish;
    end

endmodule
